FILE: design/efts_pkg.sv
`timescale 1ns / 1ps

package efts_pkg;

  typedef enum logic [2:0] {
    REG_BASE_EPOCH  = 3'd0,
    REG_BASE_MILLIS = 3'd1,
    REG_BUILD_YEAR  = 3'd2,
    REG_BUILD_MONTH = 3'd3,
    REG_BUILD_DAY   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } civil_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } clock_t;

  localparam int unsigned FLOOR_YEAR   = 2024;
  localparam int unsigned CEIL_MARGIN  = 20;
  localparam int unsigned FAT_MIN_YEAR = 1980;
  localparam int unsigned FAT_MAX_YEAR = 2107;

  localparam logic [13:0] BUILD_YEAR_RESET  = 14'd2025;
  localparam logic [3:0]  BUILD_MONTH_RESET = 4'd1;
  localparam logic [4:0]  BUILD_DAY_RESET   = 5'd1;

  localparam logic [31:0] SECS_PER_DAY = 32'd86400;

  // Reciprocal multipliers: ceil(2^k / d), exact over the operand range used.
  localparam logic [28:0] DIV1000_M  = 29'(((64'd1 << 38) + 64'd999) / 64'd1000);
  localparam logic [25:0] DIV675_M   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
  localparam logic [17:0] DIV3600_M  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] DIV60_M    = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [18:0] DIV1460_M  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] DIV36524_M = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
  localparam logic [18:0] DIV365_M   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [9:0]  DIV100_M   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
  localparam logic [11:0] DIV153_M   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
  localparam logic [11:0] DIV5_M     = 12'(((64'd1 << 14) + 64'd4) / 64'd5);

  localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
  localparam logic [19:0] ERA4_START  = 20'd584388;
  localparam logic [19:0] ERA5_START  = 20'd730485;
  localparam logic [17:0] LAST_DOE    = 18'd146096;

  localparam int unsigned SECS_LAT  = 6;
  localparam int unsigned DATE_LAT  = 11;
  localparam int unsigned CLOCK_LAT = 4;
  localparam int unsigned ALIGN_LAT = DATE_LAT - CLOCK_LAT;

endpackage

FILE: design/efts_secs.sv
`timescale 1ns / 1ps

module efts_secs import efts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] now_millis,
  input  logic [31:0] base_epoch,
  input  logic [31:0] base_millis,
  output logic        out_valid,
  output logic [15:0] days,
  output logic [16:0] sod
);

  logic        va, vb, vc, vd, ve;
  logic [31:0] diff;
  logic [60:0] prod1;
  logic [31:0] secs;
  logic [50:0] prod2;
  logic [31:0] secs_d;
  logic [15:0] days_e;
  logic [31:0] secs_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      ve        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      ve        <= vd;
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    diff   <= now_millis - base_millis;
    prod1  <= 61'(diff) * 61'(DIV1000_M);
    secs   <= base_epoch + 32'(prod1[60:38]);
    prod2  <= 51'(secs[31:7]) * 51'(DIV675_M);
    secs_d <= secs;
    days_e <= prod2[50:35];
    secs_e <= secs_d;
    days   <= days_e;
    sod    <= 17'(secs_e - 32'(days_e) * SECS_PER_DAY);
  end

  a_sod_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sod < 17'(SECS_PER_DAY)))
    else $error("seconds of day out of range");

endmodule

FILE: design/efts_clock.sv
`timescale 1ns / 1ps

module efts_clock import efts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [16:0] sod,
  output logic        out_valid,
  output clock_t      hms
);

  logic        v1, v2, v3;
  logic [34:0] ph;
  logic [16:0] sod1;
  logic [4:0]  hr2, hr3;
  logic [11:0] rem2, rem3;
  logic [24:0] pmin;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    ph         <= 35'(sod) * 35'(DIV3600_M);
    sod1       <= sod;
    hr2        <= ph[33:29];
    rem2       <= 12'(sod1 - 17'(ph[33:29]) * 17'd3600);
    pmin       <= 25'(rem2) * 25'(DIV60_M);
    hr3        <= hr2;
    rem3       <= rem2;
    hms.hour   <= hr3;
    hms.minute <= pmin[23:18];
    hms.second <= 6'(rem3 - 12'(pmin[23:18]) * 12'd60);
  end

  a_hms_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hms.hour < 5'd24 && hms.minute < 6'd60 && hms.second < 6'd60))
    else $error("time of day out of range");

endmodule

FILE: design/efts_date.sv
`timescale 1ns / 1ps

module efts_date import efts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] days,
  output logic        out_valid,
  output civil_t      civ
);

  logic [9:0]  v;
  logic [19:0] z;
  logic        era_c;

  logic [17:0] doe1, doe2, doe3, doe4, doe5, doe6;
  logic        era1, era2, era3, era4, era5, era6, era7, era8, era9;
  logic [36:0] pa, pb, py;
  logic        cen;
  logic [17:0] t3;
  logic [8:0]  yoe5, yoe6, yoe7, yoe8, yoe9;
  logic [18:0] yc6;
  logic [17:0] n6;
  logic [6:0]  q4;
  logic [8:0]  doy7, doy8, doy9, doy10;
  logic [22:0] pm8, pd10;
  logic [3:0]  mp9, month10;
  logic [11:0] year10;

  assign z     = 20'(days) + EPOCH_SHIFT;
  assign era_c = (z >= ERA5_START);

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else begin
      v         <= {v[8:0], in_valid};
      out_valid <= v[9];
    end
  end

  always_ff @(posedge clk) begin
    doe1 <= 18'(z - (era_c ? ERA5_START : ERA4_START));
    era1 <= era_c;

    pa   <= 37'(doe1) * 37'(DIV1460_M);
    pb   <= 37'(doe1) * 37'(DIV36524_M);
    cen  <= (doe1 == LAST_DOE);
    doe2 <= doe1;
    era2 <= era1;

    t3   <= doe2 - 18'(pa[36:29]) + 18'(pb[36:34]) - 18'(cen);
    doe3 <= doe2;
    era3 <= era2;

    py   <= 37'(t3) * 37'(DIV365_M);
    doe4 <= doe3;
    era4 <= era3;

    yoe5 <= py[35:27];
    doe5 <= doe4;
    era5 <= era4;

    yc6  <= 19'(yoe5) * 19'(DIV100_M);
    n6   <= 18'(yoe5) * 18'd365;
    q4   <= yoe5[8:2];
    yoe6 <= yoe5;
    doe6 <= doe5;
    era6 <= era5;

    doy7 <= 9'(doe6 - (n6 + 18'(q4) - 18'(yc6[18:16])));
    yoe7 <= yoe6;
    era7 <= era6;

    pm8  <= 23'({2'b00, doy7} * 11'd5 + 11'd2) * 23'(DIV153_M);
    doy8 <= doy7;
    yoe8 <= yoe7;
    era8 <= era7;

    mp9  <= pm8[22:19];
    doy9 <= doy8;
    yoe9 <= yoe8;
    era9 <= era8;

    pd10    <= 23'(11'(mp9) * 11'd153 + 11'd2) * 23'(DIV5_M);
    month10 <= (mp9 < 4'd10) ? mp9 + 4'd3 : mp9 - 4'd9;
    year10  <= 12'(yoe9) + (era9 ? 12'd2000 : 12'd1600) + 12'(mp9 >= 4'd10);
    doy10   <= doy9;

    civ.day   <= 5'(doy10 - pd10[22:14] + 9'd1);
    civ.month <= month10;
    civ.year  <= year10;
  end

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (civ.month >= 4'd1 && civ.month <= 4'd12))
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (civ.day != 5'd0 && civ.year >= 12'd1970))
    else $error("day or year out of range");

endmodule

FILE: design/epoch_to_fat_timestamp.sv
`timescale 1ns / 1ps
// Each accepted start passes the seconds split, then the civil-date chain, then the done register.
// Throughput: one item per cycle; busy stays low, fully pipelined reciprocal multipliers.
// The longest path is the civil-date chain (11 stages), with seconds split (6) ahead of it.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
// The receiver cannot stall: each result shows for exactly one cycle with done.

module epoch_to_fat_timestamp import efts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] now_millis,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [15:0] fat_date,
  output logic [15:0] fat_time
);

  logic [31:0] base_epoch;
  logic [31:0] base_millis;
  logic [13:0] build_year;
  logic [3:0]  build_month;
  logic [4:0]  build_day;

  logic        secs_valid;
  logic [15:0] days;
  logic [16:0] sod;
  logic        date_valid;
  civil_t      civ;
  logic        clock_valid;
  clock_t      hms;
  clock_t      align [ALIGN_LAT];

  logic        clock_ok;
  logic        build_ok;
  logic [15:0] date_clock;
  logic [15:0] date_build;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_epoch  <= '0;
      base_millis <= '0;
      build_year  <= BUILD_YEAR_RESET;
      build_month <= BUILD_MONTH_RESET;
      build_day   <= BUILD_DAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_EPOCH:  base_epoch  <= cfg_data;
        REG_BASE_MILLIS: base_millis <= cfg_data;
        REG_BUILD_YEAR:  build_year  <= cfg_data[13:0];
        REG_BUILD_MONTH: build_month <= cfg_data[3:0];
        REG_BUILD_DAY:   build_day   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  efts_secs u_secs (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start && !busy),
    .now_millis  (now_millis),
    .base_epoch  (base_epoch),
    .base_millis (base_millis),
    .out_valid   (secs_valid),
    .days        (days),
    .sod         (sod)
  );

  efts_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (secs_valid),
    .days      (days),
    .out_valid (date_valid),
    .civ       (civ)
  );

  efts_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (secs_valid),
    .sod       (sod),
    .out_valid (clock_valid),
    .hms       (hms)
  );

  // Hold the time of day until the matching date arrives.
  always_ff @(posedge clk) begin
    align[0] <= hms;
    for (int i = 1; i < ALIGN_LAT; i++) begin
      align[i] <= align[i-1];
    end
  end

  assign clock_ok = (base_epoch != 32'd0)
                 && (civ.year >= 12'(FLOOR_YEAR))
                 && (15'(civ.year) <= 15'(build_year) + 15'(CEIL_MARGIN));
  assign build_ok = (build_year >= 14'(FAT_MIN_YEAR)) && (build_year <= 14'(FAT_MAX_YEAR));

  assign date_clock = {7'(civ.year - 12'(FAT_MIN_YEAR)), civ.month, civ.day};
  assign date_build = build_ok ? {7'(build_year - 14'(FAT_MIN_YEAR)), build_month, build_day}
                               : {7'd0, 4'd1, 5'd1};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (clock_ok) begin
      fat_date <= date_clock;
      fat_time <= {align[ALIGN_LAT-1].hour, align[ALIGN_LAT-1].minute,
                   align[ALIGN_LAT-1].second[5:1]};
    end else begin
      fat_date <= date_build;
      fat_time <= '0;
    end
  end

  a_paths_aligned: assert property (@(posedge clk) disable iff (rst)
    clock_valid |-> ##(ALIGN_LAT) date_valid)
    else $error("time and date paths out of step");

endmodule
